[rtl/core/ster_pkg.sv]
// ----------------------------------------------------------------------------
// ster_pkg: shared types for the sensor threshold event reporter
// Class codes, register indices, configuration and result bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ster_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CountW    = 9;
  localparam int unsigned HystW     = 12;   // 255 * 10 fits
  localparam int unsigned HystScale = 10;   // tenths to hundredths

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_BELOW = 2'd1,
    CLS_IN    = 2'd2,
    CLS_ABOVE = 2'd3
  } class_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOWER     = 3'd0,
    REG_UPPER     = 3'd1,
    REG_HYST      = 3'd2,
    REG_TIME_BASE = 3'd3,
    REG_MIN_TIME  = 3'd4,
    REG_MAX_TIME  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] lower_threshold;
    logic signed [SampleW-1:0] upper_threshold;
    logic [7:0]                hysteresis_tenths;
    logic [7:0]                report_time_base;
    logic [7:0]                min_report_time;
    logic [7:0]                max_report_time;
  } cfg_t;

  typedef struct packed {
    class_e                    present_class;
    logic                      event_fire;
    class_e                    event_class;
    logic                      report_fire;
    logic signed [SampleW-1:0] report_value;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/ster_engine.sv]
// ----------------------------------------------------------------------------
// ster_engine: classification and report state
// Holds class history, last reported value and sample counter; works out the
// result for one sample combinationally and commits state on step_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ster_engine
  import ster_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfg_t                      cfg_i,
  input  wire logic                      cnt_load_i,
  input  wire logic [7:0]                cnt_init_i,
  input  wire logic                      step_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  output      result_t                   res_o
);

  localparam int unsigned CmpW = SampleW + 2;
  localparam int unsigned DifW = SampleW + 1;

  class_e                    cur_q, cur_d;
  class_e                    prior_q, prior_d;
  logic signed [SampleW-1:0] last_q, last_d;
  logic [CountW-1:0]         cnt_q, cnt_d;

  logic signed [CmpW-1:0] v_x, lo_x, hi_x, hy_x;
  logic [HystW-1:0]       hyst;
  logic                   enabled, first, hyst_off;
  class_e                 nxt, plain;
  logic [CountW-1:0]      cnt_inc;
  logic signed [DifW-1:0] diff;
  logic [DifW-1:0]        diff_abs;
  logic                   rep, ev;

  assign hyst = HystW'(cfg_i.hysteresis_tenths) * HystW'(HystScale);
  assign v_x  = CmpW'(sample_i);
  assign lo_x = CmpW'(cfg_i.lower_threshold);
  assign hi_x = CmpW'(cfg_i.upper_threshold);
  assign hy_x = $signed({{(CmpW-HystW){1'b0}}, hyst});

  assign enabled  = (cfg_i.report_time_base != 8'd0);
  assign first    = (cur_q == CLS_NONE);
  assign hyst_off = (cfg_i.hysteresis_tenths == 8'd0);

  always_comb begin
    if (v_x < lo_x) begin
      plain = CLS_BELOW;
    end else if (v_x >= hi_x) begin
      plain = CLS_ABOVE;
    end else begin
      plain = CLS_IN;
    end
  end

  // Hysteresis holds the present class only when re-entering the prior one
  always_comb begin
    nxt = cur_q;
    if (hyst_off || first) begin
      nxt = plain;
    end else if (plain == CLS_BELOW) begin
      if (prior_q != CLS_BELOW || v_x < lo_x - hy_x) nxt = CLS_BELOW;
    end else if (plain == CLS_ABOVE) begin
      if (prior_q != CLS_ABOVE || v_x > hi_x + hy_x) nxt = CLS_ABOVE;
    end else begin
      if (prior_q != CLS_IN || v_x > lo_x + hy_x || v_x < hi_x - hy_x) nxt = CLS_IN;
    end
  end

  assign cnt_inc  = cnt_q + CountW'(1);
  assign diff     = DifW'(last_q) - DifW'(sample_i);
  assign diff_abs = diff[DifW-1] ? DifW'(-diff) : DifW'(diff);
  assign rep      = !first && (cnt_inc > CountW'(cfg_i.min_report_time)) &&
                    ((cnt_inc > CountW'(cfg_i.max_report_time)) ||
                     (diff_abs > DifW'(hyst)));
  assign ev       = enabled && !first && (nxt != cur_q);

  always_comb begin
    cur_d   = cur_q;
    prior_d = prior_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      if (!enabled) begin
        last_d = sample_i;
      end else begin
        if (nxt != cur_q) begin
          prior_d = cur_q;
          cur_d   = nxt;
        end
        if (first) begin
          last_d = sample_i;
          cnt_d  = CountW'(cfg_i.max_report_time);
        end else if (rep) begin
          last_d = sample_i;
          cnt_d  = '0;
        end else begin
          cnt_d  = cnt_inc;
        end
      end
    end
    // a max_report_time write reloads the counter with the value being written
    if (cnt_load_i) begin
      cnt_d = CountW'(cnt_init_i);
    end
  end

  always_comb begin
    res_o.present_class = enabled ? nxt : cur_q;
    res_o.event_fire    = ev;
    res_o.event_class   = ev ? nxt : CLS_NONE;
    res_o.report_fire   = enabled && rep;
    res_o.report_value  = (enabled && rep) ? sample_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= CLS_NONE;
      prior_q <= CLS_NONE;
      last_q  <= '0;
      cnt_q   <= '0;
    end else begin
      cur_q   <= cur_d;
      prior_q <= prior_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sensor_threshold_event_reporter.sv]
// ----------------------------------------------------------------------------
// sensor_threshold_event_reporter: window comparator with hysteresis
// Classes each sample as below, in range or above a window, raises an event on
// a class change and sends status reports on time or on value movement. One
// sample is taken per clock unless in_stall_o holds the source; its result
// moves through the input register, then the result register, and is set by
// the single classify-and-report pass that lies between the two registers.
// A waiting result does not block the next sample while the input register is
// free. Configuration registers are written through a separate port that is
// always ready and should be written while no sample is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_threshold_event_reporter
  import ster_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [CfgDataW-1:0]        cfg_data_i,
  // sample in
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic signed [SampleW-1:0]  sample_value_i,
  // result out
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [1:0]                 present_class_o,
  output      logic                       event_fire_o,
  output      logic [1:0]                 event_class_o,
  output      logic                       report_fire_o,
  output      logic signed [SampleW-1:0]  report_value_o
);

  cfg_t                      cfg_q, cfg_d;
  logic                      cfg_we, cnt_load;
  logic                      s1_valid_q, s1_valid_d;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      out_valid_q, out_valid_d;
  result_t                   res, res_q;
  logic                      in_xfer, adv;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cnt_load    = cfg_we && (cfg_idx_e'(cfg_index_i) == REG_MAX_TIME);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_LOWER:     cfg_d.lower_threshold   = $signed(cfg_data_i);
        REG_UPPER:     cfg_d.upper_threshold   = $signed(cfg_data_i);
        REG_HYST:      cfg_d.hysteresis_tenths = cfg_data_i[7:0];
        REG_TIME_BASE: cfg_d.report_time_base  = cfg_data_i[7:0];
        REG_MIN_TIME:  cfg_d.min_report_time   = cfg_data_i[7:0];
        REG_MAX_TIME:  cfg_d.max_report_time   = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Stage 1 moves on whenever the result register is empty or draining
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ster_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cnt_load_i (cnt_load),
    .cnt_init_i (cfg_data_i[7:0]),
    .step_i     (adv),
    .sample_i   (s1_sample_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= sample_value_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign present_class_o = res_q.present_class;
  assign event_fire_o    = res_q.event_fire;
  assign event_class_o   = res_q.event_class;
  assign report_fire_o   = res_q.report_fire;
  assign report_value_o  = res_q.report_value;

  // An event carries the class just entered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_fire_o |-> event_class_o == present_class_o)
    else $error("event class differs from present class");

  // Neither events nor reports go out before a class exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_fire_o || report_fire_o) |-> present_class_o != CLS_NONE)
    else $error("event or report without a class");

  // Input back-pressure only while a held result blocks the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

[tb/ster_window_checker.sv]
// ----------------------------------------------------------------------------
// ster_window_checker: scoreboard for the sensor threshold event reporter
// Watches the register, sample and result channels, keeps its own copy of the
// window comparator and reporter state, and compares every result transfer
// against the oldest predicted outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ster_window_checker
  import ster_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [1:0]                present_class_i,
  input  logic                      event_fire_i,
  input  logic [1:0]                event_class_i,
  input  logic                      report_fire_i,
  input  logic signed [SampleW-1:0] report_value_i,
  output int                        pending_o,
  output int                        mismatch_count_o
);

  localparam int MaxPrinted = 40;

  cfg_t                      shadow_cfg;
  class_e                    cls_cur;
  class_e                    cls_prior;
  logic signed [SampleW-1:0] last_val;
  logic [CountW-1:0]         since_cnt;
  result_t                   sample_outcomes_q [$];

  task automatic flag_mismatch(input string msg);
    if (mismatch_count_o < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  function automatic result_t classify_and_report(input logic signed [SampleW-1:0] s);
    int      v;
    int      lo;
    int      hi;
    int      hy;
    int      delta;
    class_e  nxt;
    logic    first;
    logic    fired;
    logic    sent;
    result_t r;
    v     = s;
    lo    = shadow_cfg.lower_threshold;
    hi    = shadow_cfg.upper_threshold;
    hy    = int'(shadow_cfg.hysteresis_tenths) * HystScale;
    nxt   = cls_cur;
    fired = 1'b0;
    sent  = 1'b0;
    r     = '0;
    r.present_class = cls_cur;
    if (shadow_cfg.report_time_base == 8'd0) begin
      // disabled: value is recorded, nothing else moves
      last_val = s;
    end else begin
      first = (cls_cur == CLS_NONE);
      if (hy == 0 || first) begin
        if (v < lo) begin
          nxt = CLS_BELOW;
        end else if (v >= hi) begin
          nxt = CLS_ABOVE;
        end else begin
          nxt = CLS_IN;
        end
      end else if (v < lo) begin
        if (cls_prior != CLS_BELOW || v < lo - hy) nxt = CLS_BELOW;
      end else if (v >= hi) begin
        if (cls_prior != CLS_ABOVE || v > hi + hy) nxt = CLS_ABOVE;
      end else begin
        // in-range re-entry test is an OR of both band edges
        if (cls_prior != CLS_IN || v > lo + hy || v < hi - hy) nxt = CLS_IN;
      end
      if (nxt != cls_cur) begin
        fired     = !first;
        cls_prior = cls_cur;
        cls_cur   = nxt;
      end
      if (first) begin
        last_val  = s;
        since_cnt = {1'b0, shadow_cfg.max_report_time};
      end else begin
        since_cnt = since_cnt + 1'b1;
        delta = int'(last_val) - v;
        if (delta < 0) delta = -delta;
        if (since_cnt > {1'b0, shadow_cfg.min_report_time} &&
            (since_cnt > {1'b0, shadow_cfg.max_report_time} || delta > hy)) begin
          since_cnt = '0;
          last_val  = s;
          sent      = 1'b1;
        end
      end
      r.present_class = cls_cur;
      r.event_fire    = fired;
      r.event_class   = fired ? cls_cur : CLS_NONE;
      r.report_fire   = sent;
      r.report_value  = sent ? s : '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      shadow_cfg = '0;
      cls_cur    = CLS_NONE;
      cls_prior  = CLS_NONE;
      last_val   = '0;
      since_cnt  = '0;
      sample_outcomes_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOWER:     shadow_cfg.lower_threshold   = cfg_data_i;
          REG_UPPER:     shadow_cfg.upper_threshold   = cfg_data_i;
          REG_HYST:      shadow_cfg.hysteresis_tenths = cfg_data_i[7:0];
          REG_TIME_BASE: shadow_cfg.report_time_base  = cfg_data_i[7:0];
          REG_MIN_TIME:  shadow_cfg.min_report_time   = cfg_data_i[7:0];
          REG_MAX_TIME: begin
            shadow_cfg.max_report_time = cfg_data_i[7:0];
            since_cnt = {1'b0, cfg_data_i[7:0]};
          end
          default: ;
        endcase
      end
      // results first: a sample taken on this edge cannot already be out
      if (out_valid_i && !out_stall_i) begin
        if (sample_outcomes_q.size() == 0) begin
          flag_mismatch("result transfer with nothing outstanding");
        end else begin
          want = sample_outcomes_q.pop_front();
          if (present_class_i !== want.present_class)
            flag_mismatch($sformatf("present_class got %0h want %0h",
                                    present_class_i, want.present_class));
          if (event_fire_i !== want.event_fire)
            flag_mismatch($sformatf("event_fire got %0h want %0h",
                                    event_fire_i, want.event_fire));
          if (event_class_i !== want.event_class)
            flag_mismatch($sformatf("event_class got %0h want %0h",
                                    event_class_i, want.event_class));
          if (report_fire_i !== want.report_fire)
            flag_mismatch($sformatf("report_fire got %0h want %0h",
                                    report_fire_i, want.report_fire));
          if (report_value_i !== want.report_value)
            flag_mismatch($sformatf("report_value got %0h want %0h",
                                    report_value_i, want.report_value));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        sample_outcomes_q.push_back(classify_and_report(sample_value_i));
      end
      pending_o = sample_outcomes_q.size();
    end
  end

endmodule

[tb/sensor_threshold_event_reporter_tb.sv]
// ----------------------------------------------------------------------------
// sensor_threshold_event_reporter_tb: top-level bench for the window reporter
// Programs a series of window settings, drives directed and random samples
// under varying source gaps and sink back-pressure, and reports the verdict
// from the scoreboard module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_threshold_event_reporter_tb;
  import ster_pkg::*;

  localparam int CycleLimit     = 200000;
  localparam int SamplesPerSet  = 146;
  localparam int MaxGap         = 16;
  localparam int SettleCycles   = 8;
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgDataW-1:0]       cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [1:0]                present_class_o;
  logic                      event_fire_o;
  logic [1:0]                event_class_o;
  logic                      report_fire_o;
  logic signed [SampleW-1:0] report_value_o;

  int   pending;
  int   mismatches;
  int   cycle_count = 0;
  int   send_idle;
  int   recv_idle;
  int   walk_pos = 0;
  cfg_t active_cfg;

  int dir_stored [3]  = '{1234, -32768, 32767};
  int dir_window [17] = '{0, -200, -120, -160, -80, 0, 100, 130, 160, 90,
                          32767, -32768, -100, 50, 50, 50, 50};
  int dir_crossed [4] = '{0, 150, -150, 99};

  sensor_threshold_event_reporter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_value_i  (sample_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .present_class_o (present_class_o),
    .event_fire_o    (event_fire_o),
    .event_class_o   (event_class_o),
    .report_fire_o   (report_fire_o),
    .report_value_o  (report_value_o)
  );

  ster_window_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .present_class_i  (present_class_o),
    .event_fire_i     (event_fire_o),
    .event_class_i    (event_class_o),
    .report_fire_i    (report_fire_o),
    .report_value_i   (report_value_o),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sink back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= (int'($urandom_range(0, 99)) < recv_idle);
  end

  function automatic cfg_t make_setting(input int lo, input int hi, input int hy,
                                        input int base, input int mn, input int mx);
    cfg_t c;
    c.lower_threshold   = SampleW'(lo);
    c.upper_threshold   = SampleW'(hi);
    c.hysteresis_tenths = 8'(hy);
    c.report_time_base  = 8'(base);
    c.min_report_time   = 8'(mn);
    c.max_report_time   = 8'(mx);
    return c;
  endfunction

  function automatic cfg_t pick_setting(input int flavour);
    int   lo;
    int   span;
    cfg_t c;
    lo   = int'($urandom_range(0, 4000)) - 2000;
    span = $urandom_range(0, 1500);
    c = make_setting(lo, lo + span, $urandom_range(0, 30), $urandom_range(1, 255),
                     $urandom_range(0, 8), $urandom_range(0, 40));
    case (flavour)
      0: c = make_setting(-32768, 32767, 255, 255, 0, 0);
      1: c = make_setting(32767, -32768, 0, 1, 255, 255);
      2: c.report_time_base = '0;
      default: begin
        if ($urandom_range(0, 7) == 0) c.upper_threshold = SampleW'(lo - span);
        if ($urandom_range(0, 7) == 0) c.hysteresis_tenths = '0;
      end
    endcase
    return c;
  endfunction

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly walks around the window edges, with full-range noise mixed in
  function automatic logic signed [SampleW-1:0] pick_sample(input cfg_t c);
    int lo;
    int hi;
    int reach;
    lo    = c.lower_threshold;
    hi    = c.upper_threshold;
    reach = int'(c.hysteresis_tenths) * HystScale + 20;
    case ($urandom_range(0, 9))
      0:       walk_pos = int'($urandom_range(0, 65535)) - 32768;
      1:       walk_pos = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      2, 3:    walk_pos = lo + int'($urandom_range(0, 2 * reach)) - reach;
      4, 5:    walk_pos = hi + int'($urandom_range(0, 2 * reach)) - reach;
      default: walk_pos = walk_pos + int'($urandom_range(0, 2 * reach)) - reach;
    endcase
    walk_pos = clamp_sample(walk_pos);
    return walk_pos[SampleW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] pad_byte(input logic [7:0] b);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    return {junk, b};
  endfunction

  task automatic push_sample(input logic signed [SampleW-1:0] v);
    int   gap;
    logic taken;
    gap = 0;
    while (gap < MaxGap && int'($urandom_range(0, 99)) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // source holds off until every outstanding result has been transferred
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // expects cfg_valid_i already high
  task automatic write_word(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    logic taken;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic apply_config(input cfg_t c);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom_range(0, 65535));
    cfg_valid_i <= 1'b1;
    if ($urandom_range(0, 1) != 0) begin
      write_word(($urandom_range(0, 1) != 0) ? RegSpareA : RegSpareB, noise);
    end
    write_word(REG_LOWER, c.lower_threshold);
    write_word(REG_UPPER, c.upper_threshold);
    write_word(REG_HYST, pad_byte(c.hysteresis_tenths));
    write_word(REG_TIME_BASE, pad_byte(c.report_time_base));
    write_word(REG_MIN_TIME, pad_byte(c.min_report_time));
    write_word(REG_MAX_TIME, pad_byte(c.max_report_time));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_LOWER;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    out_stall_i    = 1'b0;
    send_idle      = 30;
    recv_idle      = 64;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: reporting off, value only recorded
    foreach (dir_stored[i]) push_sample(SampleW'(dir_stored[i]));
    drain();

    active_cfg = make_setting(-100, 100, 5, 1, 0, 3);
    apply_config(active_cfg);
    foreach (dir_window[i]) begin
      push_sample(SampleW'(dir_window[i]));
      if (i == 8) drain();
    end
    drain();

    // crossed edges, no hysteresis, slowest report timing
    active_cfg = make_setting(100, -100, 0, 255, 255, 255);
    apply_config(active_cfg);
    foreach (dir_crossed[i]) push_sample(SampleW'(dir_crossed[i]));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 30; recv_idle <= 64; end
        1: begin send_idle = 64; recv_idle <= 30; end
        default: begin send_idle = 0; recv_idle <= 0; end
      endcase
      for (int k = 0; k < 4; k++) begin
        drain();
        active_cfg = pick_setting((ph * 4 + k) % 6);
        apply_config(active_cfg);
        repeat (SamplesPerSet) push_sample(pick_sample(active_cfg));
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
